### hdl/cluster_runlist_decoder_unit_defines.svh
// Assertion macros shared by the run list decoder RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef CLUSTER_RUNLIST_DECODER_UNIT_DEFINES_SVH
`define CLUSTER_RUNLIST_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crd_pkg.sv
// Shared constants and types of the run list decoder.
// Used by the channel interfaces and by the top level; depends on nothing.
package crd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned STAT_W  = 2;

  // Largest byte count a size nibble may give.
  localparam logic [3:0] FIELD_BYTES = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STAT_W-1:0] ST_SIZE  = 2'd2;

  typedef struct packed {
    logic                     run_valid;
    logic signed [WORD_W-1:0] start_cluster;
    logic [WORD_W-1:0]        cluster_count;
    logic                     list_end;
    logic [STAT_W-1:0]        end_status;
  } out_item_t;

endpackage

### hdl/crd_if.sv
// Valid/ready channel interfaces for the run list decoder.
// Depends on crd_pkg for the payload widths.
interface crd_in_if;
  logic                         valid;
  logic                         ready;
  logic [crd_pkg::BYTE_W-1:0]   byte_value;
  logic                         last_byte;

  modport source (output valid, byte_value, last_byte, input ready);
  modport sink   (input valid, byte_value, last_byte, output ready);
endinterface

interface crd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                run_valid;
  logic signed [crd_pkg::WORD_W-1:0]   start_cluster;
  logic [crd_pkg::WORD_W-1:0]          cluster_count;
  logic                                list_end;
  logic [crd_pkg::STAT_W-1:0]          end_status;

  modport source (output valid, run_valid, start_cluster, cluster_count, list_end,
                  end_status, input ready);
  modport sink   (input valid, run_valid, start_cluster, cluster_count, list_end,
                  end_status, output ready);
endinterface

### hdl/cluster_runlist_decoder_unit.sv
// Run list decoder: takes one run list byte per request and returns decoded runs.
// Depends on crd_pkg, crd_if.sv and cluster_runlist_decoder_unit_defines.svh.
//
// The block takes one byte of a data-run list per cycle and needs no setup. Each
// byte passes an input register and is decoded against the parse state into the
// result register once that register is free or being emptied. A result is
// produced when the last byte of a run, length or offset, arrives, on a zero
// header, on a size nibble above eight, or when the final byte of the list cuts a
// run short. Inputs are taken every cycle while the result side keeps up; while a
// result waits untaken in the result register, the byte in the input register is
// not decoded, whether or not it yields a result, and the input stalls until the
// result is taken.
`include "cluster_runlist_decoder_unit_defines.svh"

module cluster_runlist_decoder_unit #(
  parameter logic [3:0] FIELD_BYTES = crd_pkg::FIELD_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  crd_in_if.sink          in_chan,
  crd_out_if.source       out_chan
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  localparam int unsigned W = crd_pkg::WORD_W;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [crd_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        s1_last_r;

  logic [1:0]   phase_r, phase_nxt;
  logic [3:0]   len_left_r, len_left_nxt;
  logic [3:0]   off_left_r, off_left_nxt;
  logic [2:0]   pos_r, pos_nxt;
  logic [W-1:0] count_r, count_nxt;
  logic [W-1:0] offset_r, offset_nxt;
  logic [W-1:0] prev_r, prev_nxt;

  logic                 out_valid_r, out_valid_nxt;
  crd_pkg::out_item_t   out_r, res;

  logic         work_go;
  logic         fire;
  logic         done;
  logic         cut_short;
  logic [3:0]   lsz, osz;
  logic [3:0]   pos_p1;
  logic [W-1:0] shifted;
  logic [W-1:0] sign_mask;
  logic [W-1:0] start_sum;

  assign work_go      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || work_go;
  assign s1_valid_nxt = (in_chan.valid && in_chan.ready) || (s1_valid_r && !work_go);
  assign out_valid_nxt = (work_go && fire) || (out_valid_r && !out_chan.ready);

  always_comb begin
    lsz       = s1_byte_r[3:0];
    osz       = s1_byte_r[7:4];
    pos_p1    = {1'b0, pos_r} + 4'd1;
    shifted   = {{(W-crd_pkg::BYTE_W){1'b0}}, s1_byte_r} << {pos_r, 3'b000};
    sign_mask = {W{1'b1}} << {pos_p1, 3'b000};
    start_sum = '0;

    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    off_left_nxt = off_left_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    offset_nxt   = offset_r;
    prev_nxt     = prev_r;

    fire      = 1'b0;
    done      = 1'b0;
    cut_short = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (s1_byte_r == '0) begin
          fire         = 1'b1;
          res.list_end = 1'b1;
          phase_nxt    = PH_DRAIN;
        end else if (lsz > FIELD_BYTES || osz > FIELD_BYTES) begin
          fire           = 1'b1;
          res.list_end   = 1'b1;
          res.end_status = crd_pkg::ST_SIZE;
          phase_nxt      = PH_DRAIN;
        end else if (s1_last_r) begin
          fire           = 1'b1;
          res.list_end   = 1'b1;
          res.end_status = crd_pkg::ST_TRUNC;
        end else begin
          len_left_nxt = lsz;
          off_left_nxt = osz;
          pos_nxt      = '0;
          count_nxt    = '0;
          offset_nxt   = '0;
          phase_nxt    = (lsz != 4'd0) ? PH_LENGTH : PH_OFFSET;
        end
      end
      PH_LENGTH: begin
        count_nxt    = count_r | shifted;
        pos_nxt      = pos_r + 3'd1;
        len_left_nxt = len_left_r - 4'd1;
        if (len_left_r == 4'd1) begin
          pos_nxt = '0;
          if (off_left_r != 4'd0) begin
            phase_nxt = PH_OFFSET;
          end else begin
            done = 1'b1;
          end
        end
        cut_short = !done;
      end
      PH_OFFSET: begin
        offset_nxt   = offset_r | shifted;
        off_left_nxt = off_left_r - 4'd1;
        pos_nxt      = pos_r + 3'd1;
        if (off_left_r == 4'd1) begin
          if (s1_byte_r[7]) begin
            offset_nxt = offset_r | shifted | sign_mask;
          end
          done = 1'b1;
        end
        cut_short = !done;
      end
      PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    if (done) begin
      start_sum         = prev_r + offset_nxt;
      fire              = 1'b1;
      res.run_valid     = 1'b1;
      res.start_cluster = start_sum;
      res.cluster_count = count_nxt;
      res.list_end      = s1_last_r;
      prev_nxt          = start_sum;
      phase_nxt         = PH_HEADER;
      len_left_nxt      = '0;
      off_left_nxt      = '0;
      pos_nxt           = '0;
      count_nxt         = '0;
      offset_nxt        = '0;
    end else if (cut_short && s1_last_r) begin
      fire           = 1'b1;
      res.list_end   = 1'b1;
      res.end_status = crd_pkg::ST_TRUNC;
    end

    if (s1_last_r) begin
      phase_nxt    = PH_HEADER;
      len_left_nxt = '0;
      off_left_nxt = '0;
      pos_nxt      = '0;
      count_nxt    = '0;
      offset_nxt   = '0;
      prev_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      len_left_r  <= '0;
      off_left_r  <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      offset_r    <= '0;
      prev_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (work_go) begin
        phase_r    <= phase_nxt;
        len_left_r <= len_left_nxt;
        off_left_r <= off_left_nxt;
        pos_r      <= pos_nxt;
        count_r    <= count_nxt;
        offset_r   <= offset_nxt;
        prev_r     <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.byte_value;
      s1_last_r <= in_chan.last_byte;
    end
    if (work_go && fire) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.run_valid     = out_r.run_valid;
  assign out_chan.start_cluster = out_r.start_cluster;
  assign out_chan.cluster_count = out_r.cluster_count;
  assign out_chan.list_end      = out_r.list_end;
  assign out_chan.end_status    = out_r.end_status;

  `CRD_ASSERT_SAME(a_empty_run_zero, out_valid_r && !out_r.run_valid, out_r.start_cluster == '0 && out_r.cluster_count == '0, "Result without a run carries nonzero fields.")
  `CRD_ASSERT_SAME(a_status_needs_end, out_valid_r && out_r.end_status != crd_pkg::ST_OK, out_r.list_end, "Error status on a result that does not end the list.")
  `CRD_ASSERT_SAME(a_header_clean, phase_r == PH_HEADER, count_r == '0 && offset_r == '0 && pos_r == '0, "Accumulators not cleared while waiting for a header.")
  `CRD_ASSERT_SAME(a_length_pending, phase_r == PH_LENGTH, len_left_r != 4'd0, "Length phase with no length bytes left.")
  `CRD_ASSERT_NEXT(a_list_boundary, work_go && s1_last_r, phase_r == PH_HEADER && prev_r == '0, "Final byte did not return the parser to a clean header state.")

endmodule

### tb/sv/cluster_runlist_decoder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the run list decoder: directed lists, then random run lists.
// Depends on crd_pkg, crd_if.sv and the top level cluster_runlist_decoder_unit.
module cluster_runlist_decoder_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_OFFSET, PH_DRAIN} parse_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  crd_in_if  in_chan ();
  crd_out_if out_chan ();

  cluster_runlist_decoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  parse_phase_t phase;
  logic [3:0]   len_left;
  logic [3:0]   off_left;
  logic [2:0]   byte_pos;
  logic [63:0]  count_acc;
  logic [63:0]  offset_acc;
  logic [63:0]  prev_start;
  crd_pkg::out_item_t expected_runs[$];

  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  out_stall = 0;
  bit           in_idle = 1'b0;
  bit           out_idle = 1'b0;

  function automatic int unsigned draw_gap(bit enabled);
    if (!enabled) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic crd_pkg::out_item_t make_result(logic run, logic [63:0] start,
                                                     logic [63:0] count, logic closes,
                                                     logic [crd_pkg::STAT_W-1:0] status);
    crd_pkg::out_item_t r;
    r.run_valid     = run;
    r.start_cluster = start;
    r.cluster_count = count;
    r.list_end      = closes;
    r.end_status    = status;
    return r;
  endfunction

  task automatic queue_result(input crd_pkg::out_item_t r);
    expected_runs.insert(expected_runs.size(), r);
  endtask

  task automatic clear_run();
    len_left   = '0;
    off_left   = '0;
    byte_pos   = '0;
    count_acc  = '0;
    offset_acc = '0;
  endtask

  task automatic close_list();
    clear_run();
    prev_start = '0;
    phase      = PH_HEADER;
  endtask

  // Advances the decoder state by one accepted byte and queues the result it causes.
  task automatic decode_expected(input logic [7:0] b, input logic last);
    logic       done;
    logic [3:0] lsz;
    logic [3:0] osz;
    logic [2:0] p;
    logic [63:0] start;
    done = 1'b0;
    lsz  = b[3:0];
    osz  = b[7:4];
    case (phase)
      PH_HEADER: begin
        if (b == 8'h00 || lsz > crd_pkg::FIELD_BYTES || osz > crd_pkg::FIELD_BYTES) begin
          queue_result(make_result(1'b0, '0, '0, 1'b1,
                                   (b == 8'h00) ? crd_pkg::ST_OK : crd_pkg::ST_SIZE));
          if (last) begin
            close_list();
          end else begin
            clear_run();
            phase = PH_DRAIN;
          end
        end else if (last) begin
          queue_result(make_result(1'b0, '0, '0, 1'b1, crd_pkg::ST_TRUNC));
          close_list();
        end else begin
          clear_run();
          len_left = lsz;
          off_left = osz;
          phase = (lsz > 0) ? PH_LENGTH : PH_OFFSET;
        end
        return;
      end
      PH_LENGTH: begin
        count_acc = count_acc | (64'(b) << (8 * byte_pos));
        byte_pos  = byte_pos + 3'd1;
        len_left  = len_left - 4'd1;
        if (len_left == 0) begin
          byte_pos = '0;
          if (off_left > 0) phase = PH_OFFSET;
          else done = 1'b1;
        end
      end
      PH_OFFSET: begin
        p = byte_pos;
        offset_acc = offset_acc | (64'(b) << (8 * p));
        off_left   = off_left - 4'd1;
        if (off_left == 0) begin
          if (b[7] && p < 3'd7) offset_acc = offset_acc | ({64{1'b1}} << (8 * (p + 1)));
          done = 1'b1;
        end
        byte_pos = p + 3'd1;
      end
      default: begin
        if (last) close_list();
        return;
      end
    endcase
    if (done) begin
      start = prev_start + offset_acc;
      prev_start = start;
      queue_result(make_result(1'b1, start, count_acc, last, crd_pkg::ST_OK));
      if (last) begin
        close_list();
      end else begin
        clear_run();
        phase = PH_HEADER;
      end
    end else if (last) begin
      queue_result(make_result(1'b0, '0, '0, 1'b1, crd_pkg::ST_TRUNC));
      close_list();
    end
  endtask

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = draw_gap(in_idle);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.byte_value <= b;
    in_chan.last_byte  <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    decode_expected(b, last);
  endtask

  task automatic send_list(input logic [8:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_runs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    crd_pkg::out_item_t want;
    bit ok;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual start %h count %h end %b",
                 $time, out_chan.start_cluster, out_chan.cluster_count, out_chan.list_end);
        mismatch_count++;
      end else begin
        want = expected_runs.pop_front();
        ok = field_ok("run_valid", 64'(want.run_valid), 64'(out_chan.run_valid));
        ok = field_ok("start_cluster", want.start_cluster, out_chan.start_cluster) && ok;
        ok = field_ok("cluster_count", want.cluster_count, out_chan.cluster_count) && ok;
        ok = field_ok("list_end", 64'(want.list_end), 64'(out_chan.list_end)) && ok;
        ok = field_ok("end_status", 64'(want.end_status), 64'(out_chan.end_status)) && ok;
        if (!ok) mismatch_count++;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    int unsigned n;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      n = draw_gap(out_idle);
      out_stall <= n;
      out_chan.ready <= (n == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_chan.ready <= (out_stall == 1);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // A negative two-byte offset, an offset-only run and a single length byte.
  task automatic test_run_forms();
    send_list('{9'h021, 9'h080, 9'h000, 9'h080, 9'h010, 9'h07F, 9'h100});
    send_list('{9'h001, 9'h1FF});
    wait_idle();
  endtask

  // Zero headers, with and without bytes to skip before the final one.
  task automatic test_list_ends();
    send_list('{9'h100});
    send_list('{9'h000, 9'h0FF, 9'h0AB, 9'h155});
    wait_idle();
  endtask

  task automatic test_size_errors();
    send_list('{9'h198});
    send_list('{9'h009, 9'h155});
    send_list('{9'h0F0, 9'h100});
    wait_idle();
  endtask

  task automatic test_truncation();
    send_list('{9'h111});
    send_list('{9'h012, 9'h1AA});
    wait_idle();
  endtask

  task automatic test_random_lists(input int unsigned target, input bit idle_in,
                                   input bit idle_out);
    logic [8:0]  seq[$];
    int unsigned sent;
    int unsigned runs;
    int unsigned lsz;
    int unsigned osz;
    int unsigned cut;
    int unsigned hi;
    int unsigned lo;
    in_idle  = idle_in;
    out_idle = idle_out;
    sent = 0;
    while (sent < target) begin
      seq = {};
      runs = $urandom_range(1, 4);
      repeat (runs) begin
        lsz = $urandom_range(0, 8);
        osz = $urandom_range(0, 8);
        if (lsz == 0 && osz == 0) lsz = 1;
        seq.insert(seq.size(), {1'b0, osz[3:0], lsz[3:0]});
        repeat (lsz + osz) seq.insert(seq.size(), {1'b0, pick_byte()});
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5: seq.insert(seq.size(), 9'h000);
        6: begin
          seq.insert(seq.size(), 9'h000);
          repeat ($urandom_range(0, 4)) seq.insert(seq.size(), {1'b0, 8'($urandom())});
          seq.insert(seq.size(), {1'b0, 8'($urandom())});
        end
        7: begin
          cut = $urandom_range(0, seq.size() - 1);
          while (seq.size() > cut + 1) void'(seq.pop_back());
        end
        8: begin
          hi = $urandom_range(9, 15);
          lo = $urandom_range(0, 15);
          if ($urandom_range(0, 1)) seq.insert(seq.size(), {1'b0, hi[3:0], lo[3:0]});
          else seq.insert(seq.size(), {1'b0, lo[3:0], hi[3:0]});
          repeat ($urandom_range(0, 3)) seq.insert(seq.size(), {1'b0, 8'($urandom())});
        end
        default: begin
          seq = {};
          repeat ($urandom_range(1, 8)) seq.insert(seq.size(), {1'b0, 8'($urandom())});
        end
      endcase
      seq[seq.size() - 1][8] = 1'b1;
      sent += seq.size();
      send_list(seq);
    end
    wait_idle();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.byte_value <= '0;
    in_chan.last_byte  <= 1'b0;
    close_list();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_run_forms();
    test_list_ends();
    test_size_errors();
    test_truncation();
    test_random_lists(100, 1'b0, 1'b0);
    test_random_lists(200, 1'b1, 1'b1);
    test_random_lists(100, 1'b0, 1'b1);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
